[sv/rlcms_pkg.sv]
// Package for the record LSH count-min sketch: sizes, item kinds and shared types.
// Used by the controller, datapath, top level and testbench; depends on nothing.
package rlcms_pkg;

  localparam int Rows         = 2;
  localparam int BucketBits   = 10;
  localparam int NumericDims  = 8;
  localparam int CategoryDims = 8;

  localparam int RowW    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int PlaneW  = (BucketBits > 1) ? $clog2(BucketBits) : 1;
  localparam int NposW   = (NumericDims > 1) ? $clog2(NumericDims) : 1;
  localparam int CposW   = (CategoryDims > 1) ? $clog2(CategoryDims) : 1;
  localparam int Planes  = Rows * BucketBits;
  localparam int PlaneIdxW = (Planes > 1) ? $clog2(Planes) : 1;
  localparam int WtDepth = Planes * NumericDims;
  localparam int WtAddrW = $clog2(WtDepth);
  localparam int CoDepth = Rows * CategoryDims;
  localparam int CoAddrW = (CoDepth > 1) ? $clog2(CoDepth) : 1;
  localparam int Buckets = 1 << BucketBits;
  localparam int CntDepth = Rows * Buckets;
  localparam int CntAddrW = $clog2(CntDepth);
  localparam int SumW    = 56;
  localparam int CntW    = 32;

  typedef enum logic [1:0] {
    KIND_LOAD_WEIGHT = 2'd0,
    KIND_LOAD_COEF   = 2'd1,
    KIND_NUMERIC     = 2'd2,
    KIND_CATEGORY    = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 capture;     // latch the accepted item
    logic                 wt_write;    // write a projection weight
    logic                 co_write;    // write a coefficient
    logic                 mac_rd;      // read weight for plane index
    logic                 mac_acc;     // accumulate product into plane sum
    logic                 cat_rd;      // read coefficient for row
    logic                 cat_acc;     // accumulate residue
    logic                 cnt_rd;      // read counter for row
    logic                 cnt_wr;      // write updated counter, fold minimum
    logic                 clear;       // clear accumulators (plane sums and residues)
    logic                 clr_write;   // write zero during clearing pass
    logic [PlaneIdxW-1:0] pidx;        // plane index row*BucketBits+plane
    logic [RowW-1:0]      ridx;        // row index
    logic [CntAddrW-1:0]  clr_addr;    // clearing pass address
  } cmd_t;

endpackage

[sv/rlcms_ram.sv]
// Generic single-port write, single-port registered-read RAM.
// Depends on nothing.
module rlcms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/rlcms_datapath.sv]
// Datapath: weight, coefficient and counter memories, shared multiplier,
// plane sums, residues and the running minimum. Depends on rlcms_pkg and rlcms_ram.
module rlcms_datapath
  import rlcms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [RowW-1:0]   row_i,
  input  logic [PlaneW-1:0] plane_i,
  input  logic [2:0]        position_i,
  input  logic [31:0]       value_i,
  input  logic [15:0]       increment_i,
  output logic [31:0]       estimate_o
);

  logic [2:0]  pos_q;
  logic [31:0] val_q;
  logic [15:0] inc_q;
  logic [RowW-1:0]   row_q;
  logic [PlaneW-1:0] plane_q;

  // Capture the item fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_q   <= position_i;
      val_q   <= value_i;
      inc_q   <= increment_i;
      row_q   <= row_i;
      plane_q <= plane_i;
    end
  end

  // Weight memory, address (row*BucketBits+plane)*NumericDims+position.
  logic [WtAddrW-1:0] wt_waddr, wt_raddr;
  logic [15:0]        wt_rdata;
  assign wt_waddr = WtAddrW'((32'(row_q) * BucketBits + 32'(plane_q)) * NumericDims
                             + 32'(pos_q));
  assign wt_raddr = WtAddrW'(32'(cmd_i.pidx) * NumericDims + 32'(pos_q));

  rlcms_ram #(.Width(16), .Depth(WtDepth)) u_wt (
    .clk_i, .we_i(cmd_i.wt_write), .waddr_i(wt_waddr), .wdata_i(val_q[15:0]),
    .raddr_i(wt_raddr), .rdata_o(wt_rdata)
  );

  // Coefficient memory, address row*CategoryDims+position.
  logic [CoAddrW-1:0]    co_waddr, co_raddr;
  logic [BucketBits-1:0] co_rdata;
  assign co_waddr = CoAddrW'(32'(row_q) * CategoryDims + 32'(pos_q));
  assign co_raddr = CoAddrW'(32'(cmd_i.ridx) * CategoryDims + 32'(pos_q));

  rlcms_ram #(.Width(BucketBits), .Depth(CoDepth)) u_co (
    .clk_i, .we_i(cmd_i.co_write), .waddr_i(co_waddr),
    .wdata_i(val_q[BucketBits-1:0]), .raddr_i(co_raddr), .rdata_o(co_rdata)
  );

  // Delayed index for the accumulate step.
  logic [PlaneIdxW-1:0] pidx_q;
  logic [RowW-1:0]      ridx_q;
  always_ff @(posedge clk_i) begin
    pidx_q <= cmd_i.pidx;
    ridx_q <= cmd_i.ridx;
  end

  // Shared 16x32 signed multiplier with registered product.
  logic signed [47:0] prod_q;
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(wt_rdata) * $signed(val_q);
  end
  logic [PlaneIdxW-1:0] pidx2_q;
  always_ff @(posedge clk_i) pidx2_q <= pidx_q;

  // Plane sums and numeric hash bits.
  logic [SumW-1:0] sums_q [Planes];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Planes; i++) sums_q[i] <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < Planes; i++) sums_q[i] <= '0;
    end else if (cmd_i.mac_acc) begin
      sums_q[pidx2_q] <= sums_q[pidx2_q] + SumW'(prod_q);
    end
  end

  // Residues: coefficient times code, modulo the bucket count.
  logic [BucketBits-1:0] res_q [Rows];
  logic [BucketBits-1:0] cat_term;
  assign cat_term = BucketBits'(co_rdata * val_q[BucketBits-1:0]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Rows; i++) res_q[i] <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < Rows; i++) res_q[i] <= '0;
    end else if (cmd_i.cat_acc) begin
      res_q[ridx_q] <= res_q[ridx_q] + cat_term;
    end
  end

  // Bucket address of a row.
  function automatic logic [CntAddrW-1:0] bucket_addr(input logic [RowW-1:0] r);
    logic [BucketBits-1:0] nh;
    for (int p = 0; p < BucketBits; p++) begin
      nh[p] = ~sums_q[PlaneIdxW'(32'(r) * BucketBits + p)][SumW-1];
    end
    return CntAddrW'(32'(r) * Buckets + 32'(BucketBits'(nh + res_q[r])));
  endfunction

  logic [CntAddrW-1:0] cnt_addr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd) cnt_addr_q <= bucket_addr(cmd_i.ridx);
  end

  // Counter memory with saturating update.
  logic [CntW-1:0] cnt_rdata, cnt_new;
  logic [CntW:0]   cnt_sum;
  logic            cnt_we;
  logic [CntAddrW-1:0] cnt_waddr;
  assign cnt_sum   = {1'b0, cnt_rdata} + (CntW+1)'(inc_q);
  assign cnt_new   = cnt_sum[CntW] ? '1 : cnt_sum[CntW-1:0];
  assign cnt_we    = cmd_i.cnt_wr | cmd_i.clr_write;
  assign cnt_waddr = cmd_i.clr_write ? cmd_i.clr_addr : cnt_addr_q;

  rlcms_ram #(.Width(CntW), .Depth(CntDepth)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr),
    .wdata_i(cmd_i.clr_write ? '0 : cnt_new),
    .raddr_i(bucket_addr(cmd_i.ridx)), .rdata_o(cnt_rdata)
  );

  // Running minimum over rows.
  logic [CntW-1:0] min_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '1;
    end else if (cmd_i.capture) begin
      min_q <= '1;
    end else if (cmd_i.cnt_wr && cnt_new < min_q) begin
      min_q <= cnt_new;
    end
  end
  assign estimate_o = min_q;

endmodule

[sv/rlcms_ctrl.sv]
// Controller: sequences loads, multiply-accumulates, residue updates, counter
// updates and the counter clearing pass. Depends on rlcms_pkg.
module rlcms_ctrl
  import rlcms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [1:0] kind_i,
  input  logic [RowW:0]   row_i,
  input  logic [4:0]      plane_i,
  input  logic [3:0]      position_i,
  input  logic       last_i,
  input  logic       out_ready_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_MAC, ST_MAC_TAIL, ST_CAT, ST_CAT_TAIL,
    ST_CNT_RD, ST_CNT_WAIT, ST_CNT_WR, ST_OUT
  } state_e;

  state_e state_q;
  logic [1:0] kind_q;
  logic       last_q, ok_q, wt_ok_q;
  logic [PlaneIdxW-1:0] pidx_q;
  logic [RowW-1:0]      ridx_q;
  logic [1:0]           tail_q;
  logic [CntAddrW-1:0]  clr_q;
  logic                 row_ok_q;
  logic                 mac_d1_q, mac_d2_q, cat_d1_q;

  // State, counters and item flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      kind_q <= KIND_LOAD_WEIGHT; last_q <= 1'b0; ok_q <= 1'b0; wt_ok_q <= 1'b0;
      pidx_q <= '0; ridx_q <= '0; tail_q <= '0; clr_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == CntDepth - 1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire_i) begin
            kind_q  <= kind_i;
            last_q  <= last_i;
            wt_ok_q <= (32'(row_i) < Rows) && (32'(plane_i) < BucketBits);
            ok_q    <= (kind_i == KIND_NUMERIC || kind_i == KIND_LOAD_WEIGHT)
                       ? 32'(position_i) < NumericDims
                       : 32'(position_i) < CategoryDims;
            pidx_q <= '0; ridx_q <= '0; tail_q <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          case (kind_q)
            KIND_LOAD_WEIGHT, KIND_LOAD_COEF: state_q <= ST_IDLE;
            KIND_NUMERIC: state_q <= ok_q ? ST_MAC : (last_q ? ST_CNT_RD : ST_IDLE);
            default:      state_q <= ok_q ? ST_CAT : (last_q ? ST_CNT_RD : ST_IDLE);
          endcase
        end
        ST_MAC: begin
          pidx_q <= pidx_q + 1'b1;
          if (32'(pidx_q) == Planes - 1) state_q <= ST_MAC_TAIL;
        end
        ST_MAC_TAIL: begin
          tail_q <= tail_q + 1'b1;
          if (tail_q == 2'd2) state_q <= last_q ? ST_CNT_RD : ST_IDLE;
        end
        ST_CAT: begin
          ridx_q <= ridx_q + 1'b1;
          if (32'(ridx_q) == Rows - 1) state_q <= ST_CAT_TAIL;
        end
        ST_CAT_TAIL: begin
          ridx_q <= '0;
          state_q <= last_q ? ST_CNT_RD : ST_IDLE;
        end
        ST_CNT_RD:   state_q <= ST_CNT_WAIT;
        ST_CNT_WAIT: state_q <= ST_CNT_WR;
        ST_CNT_WR: begin
          ridx_q <= ridx_q + 1'b1;
          state_q <= (32'(ridx_q) == Rows - 1) ? ST_OUT : ST_CNT_RD;
        end
        ST_OUT: if (out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // Command decode.
  always_comb begin
    cmd_o = '0;
    cmd_o.pidx     = pidx_q;
    cmd_o.ridx     = ridx_q;
    cmd_o.clr_addr = clr_q;
    cmd_o.capture  = in_fire_i;
    case (state_q)
      ST_CLEAR: cmd_o.clr_write = 1'b1;
      ST_LOAD: begin
        cmd_o.wt_write = (kind_q == KIND_LOAD_WEIGHT) && ok_q && wt_ok_q;
        cmd_o.co_write = (kind_q == KIND_LOAD_COEF) && ok_q && row_ok_q;
      end
      ST_MAC: cmd_o.mac_rd = 1'b1;
      ST_CAT: cmd_o.cat_rd = 1'b1;
      ST_CNT_RD: cmd_o.cnt_rd = 1'b1;
      ST_CNT_WR: cmd_o.cnt_wr = 1'b1;
      ST_OUT: cmd_o.clear = out_ready_i;
      default: ;
    endcase
    // The multiply-accumulate strobe passes through mac_d1_q and mac_d2_q, the residue strobe through cat_d1_q.
    cmd_o.mac_acc = mac_d2_q;
    cmd_o.cat_acc = cat_d1_q;
  end

  // Row validity for coefficient loads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_ok_q <= 1'b0;
    else if (in_fire_i) row_ok_q <= 32'(row_i) < Rows;
  end

  // Delay lines for accumulate strobes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_d1_q <= 1'b0; mac_d2_q <= 1'b0; cat_d1_q <= 1'b0;
    end else begin
      mac_d1_q <= (state_q == ST_MAC);
      mac_d2_q <= mac_d1_q;
      cat_d1_q <= (state_q == ST_CAT);
    end
  end

endmodule

[sv/record_lsh_count_min_sketch.sv]
// Count-min sketch of mixed records, built from a controller and a datapath.
// Depends on rlcms_pkg, rlcms_ctrl and rlcms_datapath.
//
// After reset the block clears all 2048 counters, one per cycle, accepting no
// item. A load item only passes through ST_LOAD. For a numeric feature with an
// in-range position the shared multiplier does the 20 (rows times planes)
// multiply-accumulates, one per cycle, then ST_MAC_TAIL. A categorical feature
// updates one residue per row, then ST_CAT_TAIL finishes the last residue. On
// the last feature each row's counter is read and written back, then the
// estimate waits in its output register until taken.
module record_lsh_count_min_sketch
  import rlcms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: row[0], plane[4:1], position[7:5], value[39:8], increment[55:40], zeros
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // kind
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // estimate
);

  cmd_t cmd;
  logic fire;
  assign fire = s_axis_tvalid & s_axis_tready;

  // Controller.
  rlcms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(fire), .kind_i(s_axis_tuser),
    .row_i({1'b0, s_axis_tdata[0]} ), .plane_i({1'b0, s_axis_tdata[4:1]}),
    .position_i({1'b0, s_axis_tdata[7:5]}), .last_i(s_axis_tlast),
    .out_ready_i(m_axis_tready), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .cmd_o(cmd)
  );

  // Datapath.
  rlcms_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .row_i(RowW'(s_axis_tdata[0])), .plane_i(PlaneW'(s_axis_tdata[4:1])),
    .position_i(s_axis_tdata[7:5]), .value_i(s_axis_tdata[39:8]),
    .increment_i(s_axis_tdata[55:40]), .estimate_o(m_axis_tdata)
  );

endmodule

[tb/record_lsh_count_min_sketch_tb.sv]
// Testbench for record_lsh_count_min_sketch: loads the hash tables, streams records and
// checks every estimate against a cycle-free predictor of the sketch. Depends on rlcms_pkg.
`timescale 1ns / 100ps

module record_lsh_count_min_sketch_tb;
  import rlcms_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int RandomItems = 900;

  typedef struct {
    kind_e       kind;
    bit          row;
    bit [3:0]    plane;
    bit [2:0]    pos;
    bit [31:0]   value;
    bit [15:0]   inc;
    bit          last;
  } item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  // Predictor state: tables, accumulators and counters of the sketch.
  bit signed [15:0]        proj_wt [Rows][BucketBits][NumericDims];
  bit [BucketBits-1:0]     cat_coef [Rows][CategoryDims];
  bit [SumW-1:0]           plane_acc [Rows][BucketBits];
  bit [BucketBits-1:0]     cat_res [Rows];
  bit [CntW-1:0]           counter [Rows][Buckets];

  item_t       pending_items[$];
  bit [31:0]   expected_estimates[$];
  item_t       cur_item;
  int          sent = 0;
  int          taken = 0;
  int          gap_left = 0;
  int          burst_left = 1;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  int          queued;

  record_lsh_count_min_sketch i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // row, plane, position, value, increment, zeros
    .s_axis_tuser  (s_axis_tuser),   // kind
    .s_axis_tlast  (s_axis_tlast),   // last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // estimate
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one accepted item to the sketch state and queue the estimate it yields.
  task automatic sketch_update(input item_t it);
    longint signed feat;
    longint signed prod;
    bit [BucketBits-1:0] nh;
    bit [BucketBits-1:0] bucket;
    bit [32:0] sum;
    bit [31:0] best;
    case (it.kind)
      KIND_LOAD_WEIGHT: begin
        if (it.plane < BucketBits) proj_wt[it.row][it.plane][it.pos] = it.value[15:0];
        return;
      end
      KIND_LOAD_COEF: begin
        cat_coef[it.row][it.pos] = it.value[BucketBits-1:0];
        return;
      end
      KIND_NUMERIC: begin
        feat = longint'(signed'(it.value));
        for (int r = 0; r < Rows; r++) begin
          for (int p = 0; p < BucketBits; p++) begin
            prod = longint'(proj_wt[r][p][it.pos]) * feat;
            plane_acc[r][p] = plane_acc[r][p] + prod[SumW-1:0];
          end
        end
      end
      default: begin
        // Only the low bits of the product survive the modulo.
        for (int r = 0; r < Rows; r++) begin
          cat_res[r] = cat_res[r] + cat_coef[r][it.pos] * it.value[BucketBits-1:0];
        end
      end
    endcase
    if (!it.last) return;
    best = '1;
    for (int r = 0; r < Rows; r++) begin
      for (int p = 0; p < BucketBits; p++) nh[p] = ~plane_acc[r][p][SumW-1];
      bucket = nh + cat_res[r];
      sum = counter[r][bucket] + it.inc;
      if (sum[32]) sum = 33'hFFFFFFFF;
      counter[r][bucket] = sum[31:0];
      if (sum[31:0] < best) best = sum[31:0];
      cat_res[r] = '0;
      for (int p = 0; p < BucketBits; p++) plane_acc[r][p] = '0;
    end
    expected_estimates.push_back(best);
  endtask

  task automatic add_item(input kind_e kind, input bit row, input bit [3:0] plane,
                          input bit [2:0] pos, input bit [31:0] value,
                          input bit [15:0] inc, input bit last);
    item_t it;
    it.kind = kind;
    it.row = row;
    it.plane = plane;
    it.pos = pos;
    it.value = value;
    it.inc = inc;
    it.last = last;
    pending_items.push_back(it);
    queued++;
  endtask

  function automatic bit [31:0] rand_feature();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // One record: numeric features, then categorical ones, last mark on the final item.
  task automatic add_record();
    int n_num;
    int n_cat;
    n_num = $urandom_range(0, 8);
    n_cat = (n_num == 0) ? $urandom_range(1, 8) : $urandom_range(0, 8);
    for (int i = 0; i < n_num; i++) begin
      add_item(KIND_NUMERIC, 1'($urandom), 4'($urandom), 3'($urandom), rand_feature(),
               16'($urandom), (n_cat == 0) && (i == n_num - 1));
    end
    for (int i = 0; i < n_cat; i++) begin
      add_item(KIND_CATEGORY, 1'($urandom), 4'($urandom), 3'($urandom), $urandom,
               (i == n_cat - 1 && $urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
               i == n_cat - 1);
    end
  endtask

  // Stimulus: fill both tables, directed records, then random records and noise.
  initial begin
    queued = 0;
    for (int r = 0; r < Rows; r++) begin
      for (int p = 0; p < BucketBits; p++) begin
        for (int d = 0; d < NumericDims; d++) begin
          add_item(KIND_LOAD_WEIGHT, 1'(r), 4'(p), 3'(d), $urandom, 16'($urandom), 1'b0);
        end
      end
      for (int d = 0; d < CategoryDims; d++) begin
        add_item(KIND_LOAD_COEF, 1'(r), 4'($urandom), 3'(d), $urandom, 16'($urandom),
                 1'b0);
      end
    end
    // Extreme features and increments.
    add_item(KIND_NUMERIC, 0, 0, 0, 32'h8000_0000, 16'h0000, 1'b0);
    add_item(KIND_NUMERIC, 1, 15, 7, 32'h7FFF_FFFF, 16'hFFFF, 1'b1);
    add_item(KIND_NUMERIC, 0, 0, 3, 32'h0000_0000, 16'h0000, 1'b1);
    // Categorical-only record with extreme codes.
    add_item(KIND_CATEGORY, 0, 0, 0, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    add_item(KIND_CATEGORY, 1, 0, 7, 32'h8000_0000, 16'hFFFF, 1'b1);
    // Repeated feature, missing ones.
    add_item(KIND_NUMERIC, 0, 0, 2, 32'h0001_0000, 16'h0000, 1'b0);
    add_item(KIND_NUMERIC, 0, 0, 2, 32'h0001_0000, 16'h0100, 1'b1);
    // Last mark on loads gives no estimate.
    add_item(KIND_LOAD_WEIGHT, 1, 9, 7, 32'hFFFF_8000, 16'hFFFF, 1'b1);
    add_item(KIND_LOAD_COEF, 0, 15, 0, 32'h0000_03FF, 16'hFFFF, 1'b1);
    // Weight loads with a plane out of range are dropped.
    add_item(KIND_LOAD_WEIGHT, 0, 10, 1, 32'h0000_7FFF, 16'h0, 1'b0);
    add_item(KIND_LOAD_WEIGHT, 1, 15, 6, 32'hFFFF_FFFF, 16'h0, 1'b0);
    // Loads in the middle of a record.
    add_item(KIND_NUMERIC, 0, 0, 5, 32'hFFFE_0000, 16'h0, 1'b0);
    add_item(KIND_LOAD_WEIGHT, 0, 4, 5, 32'h0000_2000, 16'h0, 1'b0);
    add_item(KIND_CATEGORY, 0, 0, 4, 32'h0000_0123, 16'h0080, 1'b1);
    // Random part: mostly well-formed records, some loads and out-of-range noise.
    while (queued < RandomItems) begin
      case ($urandom_range(0, 9))
        0: add_item(KIND_LOAD_WEIGHT, 1'($urandom), 4'($urandom), 3'($urandom), $urandom,
                    16'($urandom), 1'($urandom));
        1: add_item(KIND_LOAD_COEF, 1'($urandom), 4'($urandom), 3'($urandom), $urandom,
                    16'($urandom), 1'($urandom));
        default: add_record();
      endcase
    end
  end

  // Reset and end of run.
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_items.size() == 0 && sent == taken && expected_estimates.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && sent == taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        sent++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {8'h00, cur_item.inc, cur_item.value, cur_item.pos,
                          cur_item.plane, cur_item.row};
        s_axis_tuser  <= cur_item.kind;
        s_axis_tlast  <= cur_item.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switching among always ready, random and long stalls.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(10, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 39) == 0);
    endcase
  end

  // Result checker, predictor feed on accepted input items, and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_estimates.size() == 0) begin
        $error("unexpected estimate 0x%08h", m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== expected_estimates[0]) begin
          $error("estimate: expected 0x%08h, actual 0x%08h", expected_estimates[0],
                 m_axis_tdata);
          errors++;
        end
        void'(expected_estimates.pop_front());
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sketch_update(cur_item);
      taken++;
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
